FILE: design/fdtd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the 1-D FDTD field update engine.
// No dependencies; fdtd_cell, the top level and the testbench import this package.
package fdtd_pkg;

    localparam int CELL_CAPACITY = 1024;
    localparam int ADDR_W        = $clog2(CELL_CAPACITY);
    localparam int FIELD_W       = 32;
    localparam int INDEX_W       = 10;
    localparam int STEPS_W       = 16;
    localparam int CELLS_W       = 10;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CHAIN_LEN     = 8;
    localparam int CHAIN_W       = $clog2(CHAIN_LEN + 1);
    // Wide enough to compare an index or a cell count against the capacity.
    localparam int EXT_W         = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEPS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_IN_USE = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    localparam logic [STEPS_W-1:0] TIME_STEPS_RESET   = 16'd100;
    localparam logic [CELLS_W-1:0] CELLS_IN_USE_RESET = 10'd1023;

    typedef logic signed [FIELD_W-1:0] field_t;
    typedef logic [ADDR_W-1:0]         addr_t;

    localparam field_t FIELD_MAX = {1'b0, {(FIELD_W - 1){1'b1}}};
    localparam field_t FIELD_MIN = {1'b1, {(FIELD_W - 1){1'b0}}};

    typedef struct packed {
        logic [1:0]         req_type;
        logic [INDEX_W-1:0] cell_index;
        field_t             e_in;
        field_t             h_in;
    } in_item_t;

    typedef struct packed {
        logic               out_kind;
        logic [INDEX_W-1:0] out_index;
        field_t             out_e;
        field_t             out_h;
    } out_item_t;

    // One node of the field stream that moves down the cell chain.
    typedef struct packed {
        logic   valid;
        logic   last;
        addr_t  idx;
        field_t e;
        field_t h;
    } cell_beat_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // floor((a - b) / 2): the exact difference needs one extra bit, and dropping
    // its LSB is a floor division by two.
    function automatic field_t half_diff(field_t a, field_t b);
        logic signed [FIELD_W:0] d;
        d = {a[FIELD_W-1], a} - {b[FIELD_W-1], b};
        return d[FIELD_W:1];
    endfunction

    function automatic field_t sat_add(field_t a, field_t b);
        logic signed [FIELD_W:0] s;
        s = {a[FIELD_W-1], a} + {b[FIELD_W-1], b};
        if (s[FIELD_W] != s[FIELD_W-1])
        begin
            return s[FIELD_W] ? FIELD_MIN : FIELD_MAX;
        end
        return s[FIELD_W-1:0];
    endfunction

endpackage

FILE: design/fdtd_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module fdtd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds its value until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/fdtd_cell.sv
`timescale 1ns / 1ps
// One time-step cell of the update chain: takes the field stream of step t and
// emits the stream of step t+1 when enabled, else passes it on. Depends on fdtd_pkg.
module fdtd_cell import fdtd_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       enable,
    input  cell_beat_t in_beat,
    output cell_beat_t out_beat
);

    cell_beat_t a_reg, a_next;
    cell_beat_t b_reg, b_next;
    cell_beat_t c_reg, c_next;
    field_t     hprev_reg, hprev_next;

    // Stage A holds node i until node i+1 arrives, which supplies E[i+1] for the
    // H update. The last node has no successor and is flushed on its own.
    always_comb
    begin
        a_next       = a_reg;
        b_next       = b_reg;
        b_next.valid = 1'b0;
        if (in_beat.valid)
        begin
            a_next = in_beat;
            if (a_reg.valid)
            begin
                b_next       = a_reg;
                b_next.valid = 1'b1;
                if (enable)
                begin
                    b_next.h = sat_add(a_reg.h, half_diff(in_beat.e, a_reg.e));
                end
            end
        end
        else if (a_reg.valid && a_reg.last)
        begin
            b_next       = a_reg;
            a_next.valid = 1'b0;
        end
    end

    // Stage B updates E from the new H of this node and of the node before it.
    // The first and the last E node stay fixed.
    always_comb
    begin
        c_next     = b_reg;
        hprev_next = hprev_reg;
        if (b_reg.valid)
        begin
            hprev_next = b_reg.h;
            if (enable && !b_reg.last && (b_reg.idx != '0))
            begin
                c_next.e = sat_add(b_reg.e, half_diff(b_reg.h, hprev_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hprev_reg <= hprev_next;
    end

    assign out_beat = c_reg;

endmodule

FILE: design/fdtd_1d_field_update_engine.sv
`timescale 1ns / 1ps
// Top level of the 1-D FDTD field update engine: request decode, sweep control,
// field memories and the time-step cell chain. Depends on fdtd_pkg, fdtd_ram, fdtd_cell.
//
// Usage:
// Requests arrive on in_valid/in_ready with in_item; results leave on
// out_valid/out_ready with out_item. Configuration registers are written through
// cfg_we/cfg_index/cfg_data while the engine is idle.
// A write request stores E and H of one cell and gives no result. A read request
// returns both values through the registered memory read and the output register. Writes
// and reads can be transferred one per cycle as long as the receiver keeps taking results.
// A run request performs time_steps leapfrog steps over cells_in_use cells and then
// returns one result with out_kind set. The field memories are streamed through a
// chain of CHAIN_LEN (8) time-step cells, so one memory pass covers up to 8 steps.
// A pass reads N+1 nodes (N is cells_in_use, limited to 1023), and each node then moves
// through the registered memory read and the A, B and C registers of every cell; a run takes
// ceil(time_steps / 8) passes, and no request is taken meanwhile.
// After reset both field memories are cleared to zero by a pass over all 1024 cells,
// during which in_ready stays low; configuration writes are taken as usual.
// When the receiver stalls, one finished result waits in the output register and
// one more read may be in flight; after that in_ready drops until a transfer frees space.
module fdtd_1d_field_update_engine import fdtd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam addr_t CLEAR_LAST = ADDR_W'(CELL_CAPACITY - 1);

    state_t               state_reg, state_next;
    addr_t                clr_addr_reg, clr_addr_next;
    addr_t                rd_addr_reg, rd_addr_next;
    logic [STEPS_W-1:0]   rem_reg, rem_next;
    logic [CHAIN_W-1:0]   pass_steps_reg, pass_steps_next;
    logic [STEPS_W-1:0]   time_steps_reg;
    logic [CELLS_W-1:0]   cells_reg;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 pend_inside_reg, pend_inside_next;
    logic [INDEX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg, out_item_next;
    logic                 feed_valid_reg, feed_valid_next;
    logic                 feed_last_reg, feed_last_next;
    addr_t                feed_idx_reg, feed_idx_next;

    logic                 out_free;
    logic                 accept;
    logic                 host_inside;
    addr_t                host_addr;
    logic [EXT_W-1:0]     idx_ext;
    logic [EXT_W-1:0]     n_ext;
    logic [EXT_W-1:0]     n_lim;
    addr_t                n_eff;
    logic                 last_read;
    logic                 start_pass;
    logic [CHAIN_W-1:0]   pass_steps_calc;
    logic                 chain_done;

    logic                 ram_we;
    addr_t                ram_waddr;
    field_t               ram_wdata_e, ram_wdata_h;
    logic                 ram_re;
    addr_t                ram_raddr;
    field_t               e_rdata, h_rdata;

    cell_beat_t           chain [CHAIN_LEN + 1];

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && (!pend_valid_reg || out_free);
    assign accept   = in_valid && in_ready;

    assign idx_ext     = EXT_W'(in_item.cell_index);
    assign host_inside = idx_ext < EXT_W'(CELL_CAPACITY);
    assign host_addr   = idx_ext[ADDR_W-1:0];

    // A cell count beyond the memory is limited to the last usable H cell.
    assign n_ext = EXT_W'(cells_reg);
    assign n_lim = (n_ext > EXT_W'(CELL_CAPACITY - 1)) ? EXT_W'(CELL_CAPACITY - 1) : n_ext;
    assign n_eff = n_lim[ADDR_W-1:0];

    assign last_read       = (rd_addr_reg == n_eff);
    assign chain_done      = chain[CHAIN_LEN].valid && chain[CHAIN_LEN].last;
    assign pass_steps_calc = (rem_reg < STEPS_W'(CHAIN_LEN)) ? rem_reg[CHAIN_W-1:0]
                                                             : CHAIN_W'(CHAIN_LEN);
    assign start_pass      = (rem_reg != '0) &&
                             (((state_reg == ST_START) && !pend_valid_reg) ||
                              ((state_reg == ST_DRAIN) && chain_done));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == CLEAR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (in_item.req_type == REQ_RUN))
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = (rem_reg == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_READ:
            begin
                if (last_read)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (chain_done)
                begin
                    state_next = (rem_reg == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory ports, sweep counters and result path.
    always_comb
    begin
        clr_addr_next    = clr_addr_reg;
        rd_addr_next     = rd_addr_reg;
        rem_next         = rem_reg;
        pass_steps_next  = pass_steps_reg;
        pend_valid_next  = pend_valid_reg && !out_free;
        pend_inside_next = pend_inside_reg;
        pend_idx_next    = pend_idx_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_item_next    = out_item_reg;
        feed_valid_next  = 1'b0;
        feed_last_next   = last_read;
        feed_idx_next    = rd_addr_reg;

        ram_we      = 1'b0;
        ram_waddr   = chain[CHAIN_LEN].idx;
        ram_wdata_e = chain[CHAIN_LEN].e;
        ram_wdata_h = chain[CHAIN_LEN].h;
        ram_re      = 1'b0;
        ram_raddr   = host_addr;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata_e   = '0;
                ram_wdata_h   = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                ram_waddr   = host_addr;
                ram_wdata_e = in_item.e_in;
                ram_wdata_h = in_item.h_in;
                if (accept)
                begin
                    priority if (in_item.req_type == REQ_WRITE)
                    begin
                        ram_we = host_inside;
                    end
                    else if (in_item.req_type == REQ_READ)
                    begin
                        ram_re           = 1'b1;
                        pend_valid_next  = 1'b1;
                        pend_inside_next = host_inside;
                        pend_idx_next    = in_item.cell_index;
                    end
                    else if (in_item.req_type == REQ_RUN)
                    begin
                        rem_next = time_steps_reg;
                    end
                    else
                    begin
                        rem_next = rem_reg;
                    end
                end
            end
            ST_READ:
            begin
                ram_we          = chain[CHAIN_LEN].valid;
                ram_re          = 1'b1;
                ram_raddr       = rd_addr_reg;
                feed_valid_next = 1'b1;
                rd_addr_next    = rd_addr_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                ram_we = chain[CHAIN_LEN].valid;
            end
            ST_START, ST_DONE:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase

        if (start_pass)
        begin
            rd_addr_next    = '0;
            pass_steps_next = pass_steps_calc;
            rem_next        = rem_reg - STEPS_W'(pass_steps_calc);
        end

        // A pending read moves into the output register as soon as it is free.
        if (pend_valid_reg && out_free)
        begin
            out_valid_next          = 1'b1;
            out_item_next.out_kind  = KIND_READ;
            out_item_next.out_index = pend_idx_reg;
            out_item_next.out_e     = pend_inside_reg ? e_rdata : '0;
            out_item_next.out_h     = pend_inside_reg ? h_rdata : '0;
        end
        else if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_next          = 1'b1;
            out_item_next.out_kind  = KIND_RUN;
            out_item_next.out_index = '0;
            out_item_next.out_e     = '0;
            out_item_next.out_h     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            rd_addr_reg    <= '0;
            rem_reg        <= '0;
            pass_steps_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            feed_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            rd_addr_reg    <= rd_addr_next;
            rem_reg        <= rem_next;
            pass_steps_reg <= pass_steps_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            feed_valid_reg <= feed_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_inside_reg <= pend_inside_next;
        pend_idx_reg    <= pend_idx_next;
        out_item_reg    <= out_item_next;
        feed_last_reg   <= feed_last_next;
        feed_idx_reg    <= feed_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_steps_reg <= TIME_STEPS_RESET;
            cells_reg      <= CELLS_IN_USE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIME_STEPS:   time_steps_reg <= cfg_data[STEPS_W-1:0];
                REG_CELLS_IN_USE: cells_reg      <= cfg_data[CELLS_W-1:0];
                default:          cells_reg      <= cells_reg;
            endcase
        end
    end

    fdtd_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (CELL_CAPACITY)
    ) u_e_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata_e),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (e_rdata)
    );

    fdtd_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (CELL_CAPACITY)
    ) u_h_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata_h),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (h_rdata)
    );

    // The read data lines up with the node marker, which is registered together with the read.
    assign chain[0] = '{valid: feed_valid_reg, last: feed_last_reg, idx: feed_idx_reg,
                        e: e_rdata, h: h_rdata};

    for (genvar k = 0; k < CHAIN_LEN; k++)
    begin : g_cell
        fdtd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .enable   (CHAIN_W'(k) < pass_steps_reg),
            .in_beat  (chain[k]),
            .out_beat (chain[k + 1])
        );
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: bench/fdtd_1d_field_update_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 1-D FDTD field update engine: directed and random
// cell writes, reads and leapfrog runs, checked against a field predictor kept in the bench.
// Depends on fdtd_pkg and the fdtd_1d_field_update_engine RTL.
module fdtd_1d_field_update_engine_tb;
    import fdtd_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // Quiet cycles after the last result: covers writes still in flight in the pipeline.
    localparam int SETTLE_CYCLES = 40;
    // Timeout in nanoseconds: several times the slowest expected run.
    localparam longint RUN_LIMIT_NS = 64'd30_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fdtd_1d_field_update_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Bench copy of the field arrays and of the two registers.
    field_t             e_model [CELL_CAPACITY];
    field_t             h_model [CELL_CAPACITY];
    logic [STEPS_W-1:0] steps_cfg;
    logic [CELLS_W-1:0] cells_cfg;

    out_item_t pending_results [$];

    int send_idle_pct;
    int recv_stall_pct;
    int err_count;
    int checked_count;
    int write_count;
    int read_count;
    int run_count;
    int ignored_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results still outstanding.", pending_results.size());
        $display("** fdtd_1d_field_update_engine: FAILED **");
        $finish;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // floor((upper - lower) / 2), formed exactly in 64 bits.
    function automatic field_t half_step(field_t upper, field_t lower);
        longint delta;
        delta = longint'(upper) - longint'(lower);
        return field_t'(delta >>> 1);
    endfunction

    function automatic field_t add_clamped(field_t base, field_t inc);
        longint total;
        total = longint'(base) + longint'(inc);
        if (total > longint'(FIELD_MAX))
        begin
            return FIELD_MAX;
        end
        if (total < longint'(FIELD_MIN))
        begin
            return FIELD_MIN;
        end
        return field_t'(total);
    endfunction

    // H is updated from the old E, then the inner E nodes from the new H.
    function automatic void leapfrog_run();
        int cells;
        cells = int'(cells_cfg);
        if (cells > CELL_CAPACITY - 1)
        begin
            cells = CELL_CAPACITY - 1;
        end
        for (int t = 0; t < int'(steps_cfg); t++)
        begin
            for (int i = 0; i < cells; i++)
            begin
                h_model[i] = add_clamped(h_model[i], half_step(e_model[i + 1], e_model[i]));
            end
            for (int i = 1; i < cells; i++)
            begin
                e_model[i] = add_clamped(e_model[i], half_step(h_model[i], h_model[i - 1]));
            end
        end
    endfunction

    function automatic void predict_request(in_item_t req);
        out_item_t res;
        res = '0;
        case (req.req_type)
            REQ_WRITE:
            begin
                e_model[req.cell_index] = req.e_in;
                h_model[req.cell_index] = req.h_in;
                write_count++;
            end
            REQ_RUN:
            begin
                leapfrog_run();
                res.out_kind = KIND_RUN;
                pending_results.push_back(res);
                run_count++;
            end
            REQ_READ:
            begin
                res.out_kind  = KIND_READ;
                res.out_index = req.cell_index;
                res.out_e     = e_model[req.cell_index];
                res.out_h     = h_model[req.cell_index];
                pending_results.push_back(res);
                read_count++;
            end
            default:
            begin
                ignored_count++;
            end
        endcase
    endfunction

    task compare_field(input string label, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual kind %0d index %0d e %h h %h",
                         $time, out_item.out_kind, out_item.out_index, out_item.out_e,
                         out_item.out_h);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                checked_count++;
                compare_field("out_kind", 32'(want.out_kind), 32'(out_item.out_kind));
                compare_field("out_index", 32'(want.out_index), 32'(out_item.out_index));
                compare_field("out_e", want.out_e, out_item.out_e);
                compare_field("out_h", want.out_h, out_item.out_h);
            end
        end
    end

    function automatic in_item_t build_request(logic [1:0] kind, int idx, field_t e, field_t h);
        in_item_t req;
        req.req_type   = kind;
        req.cell_index = idx[INDEX_W-1:0];
        req.e_in       = e;
        req.h_in       = h;
        return req;
    endfunction

    // Called and left at a falling edge. Valid stays high after the transfer so that
    // back-to-back requests keep it up without a glitch.
    task send_item(input in_item_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!in_ready);
        predict_request(req);
        @(negedge clk);
    endtask

    task wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task set_register(input logic [CFG_IDX_W-1:0] which, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (which == REG_TIME_STEPS)
        begin
            steps_cfg = value[STEPS_W-1:0];
        end
        else
        begin
            cells_cfg = value[CELLS_W-1:0];
        end
    endtask

    task apply_config(input int steps, input int cells);
        wait_drained();
        set_register(REG_TIME_STEPS, steps[CFG_DATA_W-1:0]);
        set_register(REG_CELLS_IN_USE, cells[CFG_DATA_W-1:0]);
    endtask

    function automatic field_t random_field();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            case ($urandom_range(4))
                0: return FIELD_MAX;
                1: return FIELD_MIN;
                2: return '0;
                3: return '1;
                default: return field_t'(1);
            endcase
        end
        if (pick < 50)
        begin
            return field_t'(int'($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
        end
        return field_t'($urandom);
    endfunction

    // Mostly cells inside the active span, sometimes anywhere in the array.
    function automatic in_item_t random_request();
        int          pick;
        int          idx;
        logic [1:0]  kind;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            kind = REQ_WRITE;
        end
        else if (pick < 85)
        begin
            kind = REQ_READ;
        end
        else if (pick < 95)
        begin
            kind = REQ_RUN;
        end
        else
        begin
            kind = REQ_UNUSED;
        end
        if ($urandom_range(4) != 0)
        begin
            idx = $urandom_range(int'(cells_cfg));
        end
        else
        begin
            idx = $urandom_range(CELL_CAPACITY - 1);
        end
        return build_request(kind, idx, random_field(), random_field());
    endfunction

    // Cleared arrays, reset register values and a run at the reset setting, then reads of cells 500 and 501.
    task test_reset_contents();
        send_item(build_request(REQ_READ, 0, '0, '0));
        send_item(build_request(REQ_READ, CELL_CAPACITY - 1, '0, '0));
        send_item(build_request(REQ_WRITE, 500, 32'sh0001_0000, -32'sh0000_8000));
        send_item(build_request(REQ_RUN, 0, '0, '0));
        send_item(build_request(REQ_READ, 500, '0, '0));
        send_item(build_request(REQ_READ, 501, '0, '0));
    endtask

    // Extreme values, an ignored request type, and a short run that saturates.
    task test_extreme_values();
        send_item(build_request(REQ_WRITE, 0, FIELD_MIN, FIELD_MAX));
        send_item(build_request(REQ_WRITE, 1, FIELD_MAX, FIELD_MIN));
        send_item(build_request(REQ_WRITE, 2, '1, field_t'(1)));
        send_item(build_request(REQ_UNUSED, 1, field_t'(32'h1234_5678), '0));
        send_item(build_request(REQ_READ, 0, '0, '0));
        send_item(build_request(REQ_READ, 1, '0, '0));
        apply_config(1, 2);
        send_item(build_request(REQ_RUN, 0, '0, '0));
        send_item(build_request(REQ_READ, 0, '0, '0));
        send_item(build_request(REQ_READ, 1, '0, '0));
        send_item(build_request(REQ_READ, 2, '0, '0));
    endtask

    // Zero and maximum steps, the smallest and largest cell counts, pass boundaries.
    task test_config_extremes();
        apply_config(0, 2);
        send_item(build_request(REQ_RUN, 0, '0, '0));
        apply_config(65535, 2);
        send_item(build_request(REQ_RUN, 0, '0, '0));
        send_item(build_request(REQ_READ, 1, '0, '0));
        // Bits above the register width must be dropped, leaving one cell.
        apply_config(8, 32'h0000_FC01);
        send_item(build_request(REQ_RUN, 0, '0, '0));
        send_item(build_request(REQ_READ, 0, '0, '0));
        apply_config(5, 0);
        send_item(build_request(REQ_RUN, 0, '0, '0));
        apply_config(9, CELL_CAPACITY - 1);
        send_item(build_request(REQ_WRITE, CELL_CAPACITY - 1, FIELD_MAX, field_t'(-7)));
        send_item(build_request(REQ_RUN, 0, '0, '0));
        send_item(build_request(REQ_READ, CELL_CAPACITY - 2, '0, '0));
        send_item(build_request(REQ_READ, CELL_CAPACITY - 1, '0, '0));
    endtask

    task test_random_traffic(input int sender_idle, input int receiver_stall, input int goal);
        int       counted;
        int       block_left;
        int       pick;
        int       steps;
        int       cells;
        in_item_t req;
        send_idle_pct  = sender_idle;
        recv_stall_pct = receiver_stall;
        counted    = 0;
        block_left = 0;
        while (counted < goal)
        begin
            if (block_left == 0)
            begin
                pick = $urandom_range(99);
                if (pick < 5)
                begin
                    cells = CELL_CAPACITY - 1;
                    steps = $urandom_range(1, 9);
                end
                else
                begin
                    cells = (pick < 15) ? $urandom_range(49, 200) : $urandom_range(2, 48);
                    steps = ($urandom_range(3) == 0) ? $urandom_range(21, 64)
                                                     : $urandom_range(0, 20);
                end
                apply_config(steps, cells);
                block_left = 40;
            end
            else if ($urandom_range(24) == 0)
            begin
                wait_drained();
            end
            req = random_request();
            send_item(req);
            if (req.req_type != REQ_UNUSED)
            begin
                counted++;
                block_left--;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        in_valid       = 1'b0;
        in_item        = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        err_count      = 0;
        checked_count  = 0;
        write_count    = 0;
        read_count     = 0;
        run_count      = 0;
        ignored_count  = 0;
        foreach (e_model[i])
        begin
            e_model[i] = '0;
            h_model[i] = '0;
        end
        steps_cfg = TIME_STEPS_RESET;
        cells_cfg = CELLS_IN_USE_RESET;
        rst_n     = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_contents();
        test_extreme_values();
        test_config_extremes();
        test_random_traffic(0, 0, 325);
        test_random_traffic(81, 0, 325);
        test_random_traffic(0, 81, 325);
        test_random_traffic(25, 25, 325);
        wait_drained();

        $display("Sent %0d writes, %0d reads, %0d runs and %0d unused requests; %0d results checked.",
                 write_count, read_count, run_count, ignored_count, checked_count);
        $display("Runs spanned 0 to 65535 steps over 0 to 1023 cells, with and without idling.");
        if (err_count == 0)
        begin
            $display("** fdtd_1d_field_update_engine: PASSED **");
        end
        else
        begin
            $display("** fdtd_1d_field_update_engine: FAILED **");
        end
        $finish;
    end

endmodule
